[design/etf_pkg.sv]
// Shared types and constants for the escape-time fractal iterator.
// No dependencies; every other design file imports this package.
package etf_pkg;

  // Default coordinate format: signed Q4.28.
  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 28;

  // Bits of the serial operand consumed by each multiplier step.
  localparam int DIGIT_BITS = 8;

  // Iteration limit and iteration count width.
  localparam int                  ITER_WIDTH     = 16;
  localparam logic [ITER_WIDTH-1:0] MAX_ITER_RESET = 16'd100;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_UPD
  } etf_state_e;

endpackage

[design/etf_digit_mult.sv]
// Digit-serial signed multiplier: parallel multiplicand, serial multiplier digits.
// Depends on etf_pkg for the digit width.
module etf_digit_mult #(
  parameter int A_WIDTH    = 31,
  parameter int NUM_DIGITS = 4
) (
  input  logic                                                      clk_i,
  input  logic                                                      load_i,
  input  logic                                                      step_i,
  input  logic                                                      last_i,
  input  logic signed [A_WIDTH-1:0]                                 a_i,
  input  logic signed [A_WIDTH-1:0]                                 b_i,
  output logic signed [A_WIDTH+NUM_DIGITS*etf_pkg::DIGIT_BITS:0]   prod_o
);
  import etf_pkg::*;

  localparam int BW = NUM_DIGITS * DIGIT_BITS;
  localparam int TW = A_WIDTH + DIGIT_BITS + 1;

  logic signed [A_WIDTH-1:0] a_q;
  logic        [BW-1:0]      b_q, b_d;
  logic signed [A_WIDTH:0]   hi_q, hi_d;
  logic        [BW-1:0]      lo_q, lo_d;

  logic signed [BW-1:0]         b_ext;
  logic        [DIGIT_BITS-1:0] digit;
  logic signed [DIGIT_BITS:0]   digit_s;
  logic signed [TW-1:0]         partial;
  logic signed [TW-1:0]         acc;

  // The multiplier operand is sign-extended to a whole number of digits.
  assign b_ext = BW'(b_i);

  // The top digit carries the sign weight; all lower digits are unsigned.
  assign digit   = b_q[DIGIT_BITS-1:0];
  assign digit_s = last_i ? {digit[DIGIT_BITS-1], digit} : {1'b0, digit};

  // One narrow multiply-accumulate per step.
  assign partial = a_q * digit_s;
  assign acc     = partial + TW'(hi_q);

  // Low product bits retire one digit per step into the low shift register.
  always_comb begin
    hi_d = hi_q;
    lo_d = lo_q;
    b_d  = b_q;
    if (load_i) begin
      hi_d = '0;
      lo_d = '0;
      b_d  = b_ext;
    end else if (step_i) begin
      hi_d = acc[TW-1:DIGIT_BITS];
      lo_d = {acc[DIGIT_BITS-1:0], lo_q[BW-1:DIGIT_BITS]};
      b_d  = b_q >> DIGIT_BITS;
    end
  end

  // Operand and accumulator registers.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      a_q <= a_i;
    end
    hi_q <= hi_d;
    lo_q <= lo_d;
    b_q  <= b_d;
  end

  assign prod_o = {hi_q, lo_q};

endmodule

[design/escape_time_fractal_iterator.sv]
// Top level of the escape-time fractal iterator: sequencer, update arithmetic,
// limit register and three digit-serial multipliers. Depends on etf_pkg.
//
// Usage: drive c_real_i/c_imag_i and raise start while busy is low; the point
// is taken at that clock edge. The block then iterates z = z*z + c from z = 0.
// Each step feeds z to the multipliers as NUM_DIGITS digits, where NUM_DIGITS =
// ceil((FRAC_BITS + 3) / DIGIT_BITS): the three multipliers (re*re, im*im,
// re*im) consume one digit of z per cycle, then the SUM state forms re^2 - im^2
// and the radius test, and the UPD state adds c and checks the bounds. With the
// defaults NUM_DIGITS is 4, and a limit of 0 answers without running a step.
// The result appears on iteration_count_o/escaped_o, marked by done_o for
// exactly one cycle; busy falls in that same cycle, so a new request can be
// taken while the result is shown. The receiver cannot stall the block.
// The limit is written through cfg_we_i/cfg_wdata_i; the user must do so only
// while idle, which the block itself does not enforce. Reset returns the block to
// idle and sets the limit to 100.
module escape_time_fractal_iterator #(
  parameter int COORD_WIDTH = etf_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = etf_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic signed [COORD_WIDTH-1:0]  c_real_i,
  input  logic signed [COORD_WIDTH-1:0]  c_imag_i,
  input  logic                           cfg_we_i,
  input  logic [etf_pkg::ITER_WIDTH-1:0] cfg_wdata_i,
  output logic                           done_o,
  output logic [etf_pkg::ITER_WIDTH-1:0] iteration_count_o,
  output logic                           escaped_o
);
  import etf_pkg::*;

  // z is stored only while |re|,|im| <= 2, which needs FRAC_BITS + 3 bits.
  localparam int ZW = FRAC_BITS + 3;
  localparam int ND = (ZW + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int PW = ZW + 1 + ND * DIGIT_BITS;
  localparam int NW = ((PW > COORD_WIDTH) ? PW : COORD_WIDTH) + 1;
  localparam int DW = (ND > 1) ? $clog2(ND) : 1;

  localparam logic [DW-1:0]        LastDigit = DW'(ND - 1);
  localparam logic signed [NW-1:0] ZMax      = NW'(1) << (FRAC_BITS + 1);
  localparam logic signed [NW-1:0] ZMin      = -ZMax;
  localparam logic signed [PW-1:0] RadiusSq  = PW'(1) << (2 * FRAC_BITS + 2);

  etf_state_e state_q, state_d;

  logic [ITER_WIDTH-1:0] max_iter_q;
  logic [ITER_WIDTH-1:0] n_q, n_d;
  logic [DW-1:0]         dig_q, dig_d;
  logic                  done_q, done_d;
  logic [ITER_WIDTH-1:0] count_q, count_d;
  logic                  esc_q, esc_d;

  logic signed [COORD_WIDTH-1:0] c_real_q, c_imag_q;
  logic signed [PW-1:0]          diff_q;

  logic                 mul_load, mul_step, mul_last, diff_en, c_en;
  logic signed [PW-1:0] rr, ii, ri;
  logic signed [PW-1:0] sq_sum;
  logic                 sq_esc;
  logic signed [NW-1:0] nr, ni;
  logic                 bound_esc;
  logic signed [ZW-1:0] next_zr, next_zi;

  // Radius test on the squares of the current z, which are also the
  // squares needed for the next step.
  assign sq_sum = rr + ii;
  assign sq_esc = sq_sum > RadiusSq;

  // New z: floor shifts of the products plus c, then the bounds check.
  assign nr        = NW'(diff_q >>> FRAC_BITS) + NW'(c_real_q);
  assign ni        = NW'(ri >>> (FRAC_BITS - 1)) + NW'(c_imag_q);
  assign bound_esc = (nr > ZMax) || (nr < ZMin) || (ni > ZMax) || (ni < ZMin);

  // Multiplier operands: zero for a new point, else the updated z.
  assign next_zr  = (state_q == ST_IDLE) ? '0 : nr[ZW-1:0];
  assign next_zi  = (state_q == ST_IDLE) ? '0 : ni[ZW-1:0];
  assign mul_last = (dig_q == LastDigit);

  etf_digit_mult #(.A_WIDTH(ZW), .NUM_DIGITS(ND)) u_mult_rr (
    .clk_i  (clk_i),
    .load_i (mul_load),
    .step_i (mul_step),
    .last_i (mul_last),
    .a_i    (next_zr),
    .b_i    (next_zr),
    .prod_o (rr)
  );

  etf_digit_mult #(.A_WIDTH(ZW), .NUM_DIGITS(ND)) u_mult_ii (
    .clk_i  (clk_i),
    .load_i (mul_load),
    .step_i (mul_step),
    .last_i (mul_last),
    .a_i    (next_zi),
    .b_i    (next_zi),
    .prod_o (ii)
  );

  etf_digit_mult #(.A_WIDTH(ZW), .NUM_DIGITS(ND)) u_mult_ri (
    .clk_i  (clk_i),
    .load_i (mul_load),
    .step_i (mul_step),
    .last_i (mul_last),
    .a_i    (next_zr),
    .b_i    (next_zi),
    .prod_o (ri)
  );

  // Sequencer: next state, counters and result capture.
  always_comb begin
    state_d  = state_q;
    n_d      = n_q;
    dig_d    = dig_q;
    done_d   = 1'b0;
    count_d  = count_q;
    esc_d    = esc_q;
    mul_load = 1'b0;
    mul_step = 1'b0;
    diff_en  = 1'b0;
    c_en     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          c_en  = 1'b1;
          n_d   = '0;
          dig_d = '0;
          if (max_iter_q == '0) begin
            done_d  = 1'b1;
            count_d = '0;
            esc_d   = 1'b0;
          end else begin
            mul_load = 1'b1;
            state_d  = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        mul_step = 1'b1;
        if (mul_last) begin
          dig_d   = '0;
          state_d = ST_SUM;
        end else begin
          dig_d = dig_q + 1'b1;
        end
      end
      ST_SUM: begin
        diff_en = 1'b1;
        if (sq_esc) begin
          // The squares belong to the previous step's result.
          done_d  = 1'b1;
          count_d = n_q - 1'b1;
          esc_d   = 1'b1;
          state_d = ST_IDLE;
        end else if (n_q == max_iter_q) begin
          done_d  = 1'b1;
          count_d = max_iter_q;
          esc_d   = 1'b0;
          state_d = ST_IDLE;
        end else begin
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        n_d = n_q + 1'b1;
        if (bound_esc) begin
          done_d  = 1'b1;
          count_d = n_q;
          esc_d   = 1'b1;
          state_d = ST_IDLE;
        end else begin
          mul_load = 1'b1;
          state_d  = ST_MUL;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control and configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      max_iter_q <= MAX_ITER_RESET;
      n_q        <= '0;
      dig_q      <= '0;
      done_q     <= 1'b0;
      count_q    <= '0;
      esc_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        max_iter_q <= cfg_wdata_i;
      end
      n_q     <= n_d;
      dig_q   <= dig_d;
      done_q  <= done_d;
      count_q <= count_d;
      esc_q   <= esc_d;
    end
  end

  // Payload registers: the point and the real-part difference.
  always_ff @(posedge clk_i) begin
    if (c_en) begin
      c_real_q <= c_real_i;
      c_imag_q <= c_imag_i;
    end
    if (diff_en) begin
      diff_q <= rr - ii;
    end
  end

  assign busy              = (state_q != ST_IDLE);
  assign done_o            = done_q;
  assign iteration_count_o = count_q;
  assign escaped_o         = esc_q;

endmodule

[dv/etf_checker.sv]
`timescale 1ns / 100ps
// Checker for the escape-time fractal iterator: it watches requests, limit writes and
// results, predicts every result on its own, and compares field by field.
// Depends on etf_pkg for the coordinate format and the iteration count width.
module etf_checker (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      start_i,
  input  logic                                      busy_i,
  input  logic signed [etf_pkg::COORD_WIDTH_DEF-1:0] c_real_i,
  input  logic signed [etf_pkg::COORD_WIDTH_DEF-1:0] c_imag_i,
  input  logic                                      cfg_we_i,
  input  logic [etf_pkg::ITER_WIDTH-1:0]            cfg_wdata_i,
  input  logic                                      done_i,
  input  logic [etf_pkg::ITER_WIDTH-1:0]            iteration_count_i,
  input  logic                                      escaped_i,
  output int                                        mismatches_o,
  output int                                        outstanding_o,
  output int                                        escaped_total_o,
  output int                                        bounded_total_o
);
  import etf_pkg::*;

  localparam int     FRAC    = FRAC_BITS_DEF;
  // Bounds in z's format: 2 with FRAC fraction bits, 4 with 2*FRAC.
  localparam longint TWO_Z   = longint'(2) <<< FRAC;
  localparam longint FOUR_ZZ = longint'(4) <<< (2 * FRAC);

  typedef struct {
    int unsigned           point_id;
    logic [ITER_WIDTH-1:0] count;
    logic                  escaped;
  } escape_result_t;

  escape_result_t        pending_escapes[$];
  escape_result_t        oldest_escape;
  escape_result_t        new_escape;
  logic [ITER_WIDTH-1:0] iter_limit;
  int unsigned           points_seen;
  int                    mismatch_total;
  int                    escaped_total;
  int                    bounded_total;

  // Iterates z = z*z + c from z = 0 under the given limit. Products are exact and each
  // rescale is an arithmetic shift, which floors toward minus infinity.
  function automatic escape_result_t predict_escape(
    input logic signed [COORD_WIDTH_DEF-1:0] c_re,
    input logic signed [COORD_WIDTH_DEF-1:0] c_im,
    input logic [ITER_WIDTH-1:0]             limit
  );
    escape_result_t res;
    longint         cr;
    longint         ci;
    longint         zr;
    longint         zi;
    longint         nr;
    longint         ni;
    int unsigned    step;
    logic           esc;
    cr   = c_re;
    ci   = c_im;
    zr   = 0;
    zi   = 0;
    step = 0;
    esc  = 1'b0;
    while (!esc && step < limit) begin
      nr = ((zr * zr - zi * zi) >>> FRAC) + cr;
      ni = ((zr * zi * 2) >>> FRAC) + ci;
      zr = nr;
      zi = ni;
      // A part beyond 2 escapes outright; otherwise the radius test is exact.
      if (zr > TWO_Z || zr < -TWO_Z || zi > TWO_Z || zi < -TWO_Z) begin
        esc = 1'b1;
      end else if (zr * zr + zi * zi > FOUR_ZZ) begin
        esc = 1'b1;
      end else begin
        step++;
      end
    end
    res.point_id = 0;
    res.count    = step[ITER_WIDTH-1:0];
    res.escaped  = esc;
    return res;
  endfunction

  // Prints one line per mismatch and counts it.
  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_total++;
  endtask

  // Results are matched before a new request is queued, since a request can be
  // taken in the same cycle that the previous result is shown.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_escapes.delete();
      iter_limit      <= MAX_ITER_RESET;
      points_seen     = 0;
      mismatch_total  = 0;
      escaped_total   = 0;
      bounded_total   = 0;
      mismatches_o    <= 0;
      outstanding_o   <= 0;
      escaped_total_o <= 0;
      bounded_total_o <= 0;
    end else begin
      if (done_i) begin
        if (pending_escapes.size() == 0) begin
          report_mismatch($sformatf("result count=%0d escaped=%0b with no point pending",
                                    iteration_count_i, escaped_i));
        end else begin
          oldest_escape = pending_escapes.pop_front();
          if (iteration_count_i !== oldest_escape.count) begin
            report_mismatch($sformatf("point %0d: iteration_count got %0d want %0d",
                                      oldest_escape.point_id, iteration_count_i,
                                      oldest_escape.count));
          end
          if (escaped_i !== oldest_escape.escaped) begin
            report_mismatch($sformatf("point %0d: escaped got %0b want %0b",
                                      oldest_escape.point_id, escaped_i,
                                      oldest_escape.escaped));
          end
          if (oldest_escape.escaped) begin
            escaped_total++;
          end else begin
            bounded_total++;
          end
        end
      end
      if (start_i && !busy_i) begin
        new_escape          = predict_escape(c_real_i, c_imag_i, iter_limit);
        new_escape.point_id = points_seen;
        points_seen++;
        pending_escapes.push_back(new_escape);
      end
      if (cfg_we_i) begin
        iter_limit <= cfg_wdata_i;
      end
      mismatches_o    <= mismatch_total;
      outstanding_o   <= pending_escapes.size();
      escaped_total_o <= escaped_total;
      bounded_total_o <= bounded_total;
    end
  end

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps
// Top of the escape-time fractal iterator testbench: clock, reset, limit writes and
// point requests, then the verdict. Depends on etf_pkg, the block and etf_checker.
module testbench;
  import etf_pkg::*;

  localparam int CW               = COORD_WIDTH_DEF;
  localparam int RANDOM_PHASES    = 8;
  localparam int POINTS_PER_PHASE = 116;
  // Slowest correct run: every random point bounded at a limit of 255, one bounded point
  // at the largest limit and sender gaps.
  localparam longint CYCLE_LIMIT  = 8_000_000;

  // Coordinates in Q4.28.
  localparam logic signed [CW-1:0] Q_ZERO = '0;
  localparam logic signed [CW-1:0] Q_ONE  = 32'sd268435456;
  localparam logic signed [CW-1:0] Q_TWO  = 32'sd536870912;
  localparam logic signed [CW-1:0] Q_MIN  = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [CW-1:0] Q_MAX  = {1'b0, {(CW-1){1'b1}}};

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  start       = 1'b0;
  logic                  busy;
  logic signed [CW-1:0]  c_real_i    = '0;
  logic signed [CW-1:0]  c_imag_i    = '0;
  logic                  cfg_we_i    = 1'b0;
  logic [ITER_WIDTH-1:0] cfg_wdata_i = '0;
  logic                  done_o;
  logic [ITER_WIDTH-1:0] iteration_count_o;
  logic                  escaped_o;

  int     mismatches;
  int     outstanding;
  int     escaped_total;
  int     bounded_total;
  int     sender_idle_pct = 0;
  int     points_sent     = 0;
  int     limits_written  = 0;
  longint cycle_count     = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  escape_time_fractal_iterator i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .c_real_i          (c_real_i),
    .c_imag_i          (c_imag_i),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .done_o            (done_o),
    .iteration_count_o (iteration_count_o),
    .escaped_o         (escaped_o)
  );

  etf_checker i_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start),
    .busy_i            (busy),
    .c_real_i          (c_real_i),
    .c_imag_i          (c_imag_i),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .done_i            (done_o),
    .iteration_count_i (iteration_count_o),
    .escaped_i         (escaped_o),
    .mismatches_o      (mismatches),
    .outstanding_o     (outstanding),
    .escaped_total_o   (escaped_total),
    .bounded_total_o   (bounded_total)
  );

  // Hard stop if the run hangs.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results outstanding", cycle_count,
               outstanding);
      $display("status: fail");
      $finish;
    end
  end

  // Points just off the set's boundary, which take many steps to decide.
  function automatic void boundary_base(input int unsigned sel,
                                        output logic signed [CW-1:0] re,
                                        output logic signed [CW-1:0] im);
    case (sel)
      0:       begin re = -32'sd201326592; im = 32'sd26843546;  end
      1:       begin re = 32'sd67108864;   im = 32'sd0;         end
      2:       begin re = -32'sd335544320; im = 32'sd0;         end
      3:       begin re = -32'sd26843546;  im = 32'sd174483046; end
      4:       begin re = 32'sd75161928;   im = 32'sd142270792; end
      5:       begin re = -32'sd475130757; im = 32'sd0;         end
      default: begin re = -32'sd42949673;  im = 32'sd279172874; end
    endcase
  endfunction

  // Coordinates at the format's ends and right around the escape bound.
  function automatic logic signed [CW-1:0] edge_coord(input int unsigned sel);
    case (sel)
      0:       return Q_MIN;
      1:       return Q_MAX;
      2:       return Q_ZERO;
      3:       return -1;
      4:       return Q_TWO;
      5:       return -Q_TWO;
      6:       return Q_TWO + 1;
      7:       return -Q_TWO - 1;
      8:       return Q_TWO - 1;
      default: return -Q_TWO + 1;
    endcase
  endfunction

  // Mostly points in the usual view window or near the boundary; the rest spread
  // over wider ranges, all 32-bit patterns and the edge values.
  function automatic void random_point(output logic signed [CW-1:0] re,
                                       output logic signed [CW-1:0] im);
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 45) begin
      re = -32'sd603979776 + $urandom_range(805306368);
      im = -32'sd402653184 + $urandom_range(805306368);
    end else if (pick < 65) begin
      boundary_base($urandom_range(6), re, im);
      re = re + $urandom_range(2097152) - 1048576;
      im = im + $urandom_range(2097152) - 1048576;
    end else if (pick < 80) begin
      re = -32'sd1073741824 + $urandom_range(2147483647);
      im = -32'sd1073741824 + $urandom_range(2147483647);
    end else if (pick < 95) begin
      re = $urandom;
      im = $urandom;
    end else begin
      re = edge_coord($urandom_range(9));
      im = edge_coord($urandom_range(9));
    end
  endfunction

  // Issues one request and returns once the block has taken it.
  task automatic send_point(input logic signed [CW-1:0] re, input logic signed [CW-1:0] im);
    // Sometimes let the block go idle first, so gaps also fall after the result.
    if (sender_idle_pct != 0 && $urandom_range(1) == 1) begin
      start <= 1'b0;
      do @(posedge clk_i); while (busy);
    end
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start    <= 1'b1;
    c_real_i <= re;
    c_imag_i <= im;
    do @(posedge clk_i); while (busy);
    points_sent++;
  endtask

  // Writes the iteration limit once every pending result has come back.
  task automatic write_limit(input logic [ITER_WIDTH-1:0] value);
    start <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0 || busy) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    limits_written++;
  endtask

  initial begin : stimulus
    logic signed [CW-1:0] re;
    logic signed [CW-1:0] im;
    int unsigned          phase_limit [RANDOM_PHASES];
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset limit of 100: origin, exact radius on both axes, format ends, a cycle
    // of period two, the cusp, points inside and the smallest negative step.
    send_point(Q_ZERO, Q_ZERO);
    send_point(-Q_TWO, Q_ZERO);
    send_point(Q_TWO, Q_ZERO);
    send_point(Q_ZERO, Q_TWO);
    send_point(Q_ZERO, -Q_TWO);
    send_point(Q_MAX, Q_MAX);
    send_point(Q_MIN, Q_MIN);
    send_point(Q_MAX, Q_MIN);
    send_point(Q_MIN, Q_MAX);
    send_point(-Q_ONE, Q_ZERO);
    send_point(32'sd67108864, Q_ZERO);
    send_point(-32'sd201326592, 32'sd26843546);
    send_point(-1, -1);
    send_point(32'sd80530637, 32'sd134217728);

    // A limit of zero runs no step at all.
    write_limit('0);
    send_point(Q_ZERO, Q_ZERO);
    send_point(Q_MAX, Q_MAX);

    // A limit of one: bounded, bounded on the escape radius, escaping on the first.
    write_limit(16'd1);
    send_point(Q_ZERO, Q_ZERO);
    send_point(Q_TWO, Q_ZERO);
    send_point(Q_MAX, Q_ZERO);

    // Largest limit: one bounded point runs the full count, the others escape.
    write_limit('1);
    send_point(Q_ZERO, Q_ZERO);
    send_point(32'sd69793219, Q_ZERO);
    send_point(Q_MIN, Q_MIN);

    // Random points under a spread of small and moderate limits.
    phase_limit[0] = MAX_ITER_RESET;
    phase_limit[1] = $urandom_range(63, 2);
    phase_limit[2] = 255;
    phase_limit[3] = 1;
    phase_limit[4] = 32;
    phase_limit[5] = $urandom_range(200, 64);
    phase_limit[6] = 3;
    phase_limit[7] = $urandom_range(255, 1);
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      write_limit(phase_limit[phase][ITER_WIDTH-1:0]);
      case (phase % 4)
        1:       sender_idle_pct = 58;
        3:       sender_idle_pct = 29;
        default: sender_idle_pct = 0;
      endcase
      for (int k = 0; k < POINTS_PER_PHASE; k++) begin
        random_point(re, im);
        send_point(re, im);
      end
    end
    start <= 1'b0;

    // Drain, then give the block time to show any stray result.
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);

    $display("Sent %0d points under %0d iteration limits, from 0 to 65535.", points_sent,
             limits_written + 1);
    $display("%0d points escaped, %0d stayed bounded, %0d mismatches.", escaped_total,
             bounded_total, mismatches);
    if (mismatches == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
